// ----- rtl/gss_pkg.sv -----
// shared types, constants and vector helpers of the gjk simplex step unit
package gss_pkg;

	localparam int CW = 16;              // coordinate width
	localparam int DW = 64;              // direction component width
	localparam int SW = CW + 2;          // small operand width (differences, negation)
	localparam int PRW = DW + SW;        // product width
	localparam int AW = PRW + 6;         // accumulator width
	localparam int IN_W = ((3 * CW + 7) / 8) * 8;
	localparam int OUT_FW = 3 * DW + 3 * CW + 2;
	localparam int OUT_W = ((OUT_FW + 7) / 8) * 8;
	localparam int NVTX = 4;

	localparam logic OP_START = 1'b0;
	localparam logic OP_CONT = 1'b1;

	localparam logic [1:0] ST_CONT = 2'd0;
	localparam logic [1:0] ST_INT = 2'd1;
	localparam logic [1:0] ST_SEP = 2'd2;
	localparam logic [1:0] ST_IGN = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
	} cvec_t;

	typedef struct packed {
		logic signed [SW-1:0] z;
		logic signed [SW-1:0] y;
		logic signed [SW-1:0] x;
	} svec_t;

	typedef struct packed {
		logic signed [DW-1:0] z;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] x;
	} dvec_t;

	// job request to the shared mac unit
	typedef struct packed {
		logic start;
		logic dot;
		logic neg;
	} mac_cmd_t;

	typedef struct packed {
		logic done;
		logic pos;
	} mac_rsp_t;

	// u - v at small width
	function automatic svec_t vdiff(cvec_t u, cvec_t v);
		svec_t r;
		r.x = SW'(u.x) - SW'(v.x);
		r.y = SW'(u.y) - SW'(v.y);
		r.z = SW'(u.z) - SW'(v.z);
		return r;
	endfunction

	function automatic dvec_t s2d(svec_t s);
		dvec_t r;
		r.x = DW'(s.x);
		r.y = DW'(s.y);
		r.z = DW'(s.z);
		return r;
	endfunction

	function automatic dvec_t dneg(dvec_t d);
		dvec_t r;
		r.x = -d.x;
		r.y = -d.y;
		r.z = -d.z;
		return r;
	endfunction

endpackage

// ----- rtl/gjk_simplex_step_unit.sv -----
// top level of the gjk simplex step unit: sequencer, simplex state and stream ports
//
// usage: the host sends one support point per input word on the s_axis channel.
// tuser selects start (seed a new query) or continue (next support point for the
// direction last returned). each input word yields one or more output words on
// m_axis: one status-continue word with the new search direction, one ignored
// word when no query runs, or the simplex vertices newest first (status
// separated, 1 to 3 words; status intersecting, 4 words), tlast on the final one.
// flow: start and ignored words go straight to output; a continue word runs
// the dot test and then the line, triangle or tetrahedron case on the shared
// 64x18 multiply-accumulate unit, one product term at a time, the tetrahedron
// case falling into the triangle case being the longest. the block takes one
// input word at a time and holds s_axis_tready low from acceptance until its
// last output word is taken.
// a stalled receiver simply holds the output word; nothing is lost.
// reset clears the query, the simplex count and the sequencer; no query is active.
module gjk_simplex_step_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [gss_pkg::IN_W-1:0]    s_axis_tdata,  // point_x, point_y, point_z
	input  logic                        s_axis_tuser,  // opcode
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// dir_x, dir_y, dir_z, vertex_x, vertex_y, vertex_z, vertex_index, zero pad
	output logic [gss_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic [1:0]                  m_axis_tuser,  // status
	output logic                        m_axis_tlast
);
	import gss_pkg::*;

	// sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_D0   = 5'd1;   // dot(dir, p)
	localparam logic [4:0] S_LDOT = 5'd2;   // dot(ab, ao)
	localparam logic [4:0] S_LX1  = 5'd3;   // t2 = ab x ao
	localparam logic [4:0] S_LX2  = 5'd4;   // dir = t2 x ab
	localparam logic [4:0] S_TX1  = 5'd5;   // t1 = ab x ac
	localparam logic [4:0] S_TX2  = 5'd6;   // t2 = t1 x ac
	localparam logic [4:0] S_TD1  = 5'd7;   // dot(t2, ao)
	localparam logic [4:0] S_TD2  = 5'd8;   // dot(ac, ao)
	localparam logic [4:0] S_TX3  = 5'd9;   // t2 = ac x ao
	localparam logic [4:0] S_TX4  = 5'd10;  // dir = t2 x ac
	localparam logic [4:0] S_TX5  = 5'd11;  // t2 = ab x t1
	localparam logic [4:0] S_TD3  = 5'd12;  // dot(t2, ao)
	localparam logic [4:0] S_TD4  = 5'd13;  // dot(t1, ao)
	localparam logic [4:0] S_QX1  = 5'd14;  // t1 = ab x ac
	localparam logic [4:0] S_QD1  = 5'd15;
	localparam logic [4:0] S_QX2  = 5'd16;  // t1 = ac x ad
	localparam logic [4:0] S_QD2  = 5'd17;
	localparam logic [4:0] S_QX3  = 5'd18;  // t1 = ad x ab
	localparam logic [4:0] S_QD3  = 5'd19;
	localparam logic [4:0] S_EMIT = 5'd20;

	logic [4:0] state_q;
	logic go_q, active_q;
	logic [2:0] count_q, n_q, count_inc;
	logic [1:0] k_q, status_q;

	// simplex vertices: a newest, then b, c, d
	cvec_t a_q, b_q, c_q, d_q, p_q, p_in, vsel;
	dvec_t dir_q, t1_q, t2_q;
	svec_t ab, ac, ad, ao;

	mac_cmd_t cmd;
	mac_rsp_t rsp;
	dvec_t big_op, mac_res;
	svec_t small_op;
	logic is_dot, is_neg, computing, in_acc, out_acc, out_last;

	assign p_in = s_axis_tdata[3*CW-1:0];
	assign ab = vdiff(b_q, a_q);
	assign ac = vdiff(c_q, a_q);
	assign ad = vdiff(d_q, a_q);
	assign ao = vdiff(cvec_t'('0), a_q);
	assign count_inc = (count_q == 3'(NVTX)) ? count_q : count_q + 3'd1;

	assign computing = (state_q != S_IDLE) && (state_q != S_EMIT);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign out_last = ({1'b0, k_q} + 3'd1) == n_q;

	// operand routing per step
	always_comb begin
		big_op = dir_q;
		small_op = ao;
		is_dot = 1'b0;
		is_neg = 1'b0;
		case (state_q)
			S_D0: begin
				big_op = dir_q;
				small_op = vdiff(p_q, cvec_t'('0));
				is_dot = 1'b1;
			end
			S_LDOT: begin big_op = s2d(ab); small_op = ao; is_dot = 1'b1; end
			S_LX1: begin big_op = s2d(ab); small_op = ao; end
			S_LX2: begin big_op = t2_q; small_op = ab; end
			S_TX1, S_QX1: begin big_op = s2d(ab); small_op = ac; end
			S_TX2: begin big_op = t1_q; small_op = ac; end
			S_TD1, S_TD3: begin big_op = t2_q; small_op = ao; is_dot = 1'b1; end
			S_TD2: begin big_op = s2d(ac); small_op = ao; is_dot = 1'b1; end
			S_TX3: begin big_op = s2d(ac); small_op = ao; end
			S_TX4: begin big_op = t2_q; small_op = ac; end
			// ab x abc is minus abc x ab
			S_TX5: begin big_op = t1_q; small_op = ab; is_neg = 1'b1; end
			S_TD4, S_QD1, S_QD2, S_QD3: begin
				big_op = t1_q;
				small_op = ao;
				is_dot = 1'b1;
			end
			S_QX2: begin big_op = s2d(ac); small_op = ad; end
			S_QX3: begin big_op = s2d(ad); small_op = ab; end
			default: begin big_op = dir_q; small_op = ao; end
		endcase
	end

	assign cmd.start = computing && !go_q;
	assign cmd.dot = is_dot;
	assign cmd.neg = is_neg;

	gss_mac_unit u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.big_op   (big_op),
		.small_op (small_op),
		.rsp      (rsp),
		.res      (mac_res)
	);

	// control: sequencer, query flag, simplex count, emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q <= 1'b0;
			active_q <= 1'b0;
			count_q <= 3'd0;
			n_q <= 3'd0;
			k_q <= 2'd0;
			status_q <= ST_CONT;
		end else begin
			if (cmd.start) begin
				go_q <= 1'b1;
			end
			if (rsp.done) begin
				go_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						k_q <= 2'd0;
						n_q <= 3'd1;
						if (s_axis_tuser == OP_START) begin
							active_q <= 1'b1;
							count_q <= 3'd1;
							status_q <= ST_CONT;
							state_q <= S_EMIT;
						end else if (!active_q) begin
							status_q <= ST_IGN;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_D0;
						end
					end
				end
				S_D0: if (rsp.done) begin
					if (!rsp.pos) begin
						status_q <= ST_SEP;
						n_q <= count_q;
						active_q <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						count_q <= count_inc;
						case (count_inc)
							3'd2: state_q <= S_LDOT;
							3'd3: state_q <= S_TX1;
							default: state_q <= S_QX1;
						endcase
					end
				end
				S_LDOT: if (rsp.done) begin
					if (rsp.pos) begin
						state_q <= S_LX1;
					end else begin
						count_q <= 3'd1;
						status_q <= ST_CONT;
						state_q <= S_EMIT;
					end
				end
				S_LX1: if (rsp.done) state_q <= S_LX2;
				S_LX2, S_TX4: if (rsp.done) begin
					status_q <= ST_CONT;
					state_q <= S_EMIT;
				end
				S_TX1: if (rsp.done) state_q <= S_TX2;
				S_TX2: if (rsp.done) state_q <= S_TD1;
				S_TD1: if (rsp.done) state_q <= rsp.pos ? S_TD2 : S_TX5;
				S_TD2: if (rsp.done) begin
					count_q <= 3'd2;
					state_q <= rsp.pos ? S_TX3 : S_LDOT;
				end
				S_TX3: if (rsp.done) state_q <= S_TX4;
				S_TX5: if (rsp.done) state_q <= S_TD3;
				S_TD3: if (rsp.done) begin
					if (rsp.pos) begin
						count_q <= 3'd2;
						state_q <= S_LDOT;
					end else begin
						state_q <= S_TD4;
					end
				end
				S_TD4: if (rsp.done) begin
					status_q <= ST_CONT;
					state_q <= S_EMIT;
				end
				S_QX1: if (rsp.done) state_q <= S_QD1;
				S_QX2: if (rsp.done) state_q <= S_QD2;
				S_QX3: if (rsp.done) state_q <= S_QD3;
				S_QD1, S_QD2: if (rsp.done) begin
					if (rsp.pos) begin
						count_q <= 3'd3;
						state_q <= S_TX1;
					end else begin
						state_q <= (state_q == S_QD1) ? S_QX2 : S_QX3;
					end
				end
				S_QD3: if (rsp.done) begin
					if (rsp.pos) begin
						count_q <= 3'd3;
						state_q <= S_TX1;
					end else begin
						status_q <= ST_INT;
						n_q <= 3'(NVTX);
						active_q <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (out_acc) begin
					if (out_last) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: vertices, point, direction and cross-product temporaries
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			p_q <= p_in;
			if (s_axis_tuser == OP_START) begin
				a_q <= p_in;
				dir_q <= s2d(vdiff(cvec_t'('0), p_in));
			end
		end
		if (rsp.done) begin
			case (state_q)
				S_D0: if (rsp.pos) begin
					a_q <= p_q;
					b_q <= a_q;
					c_q <= b_q;
					d_q <= c_q;
				end
				S_LDOT: if (!rsp.pos) dir_q <= s2d(ao);
				S_LX1, S_TX2, S_TX3, S_TX5: t2_q <= mac_res;
				S_LX2, S_TX4: dir_q <= mac_res;
				S_TX1, S_QX1, S_QX2, S_QX3: t1_q <= mac_res;
				S_TD2: if (rsp.pos) b_q <= c_q;
				S_TD4: begin
					if (rsp.pos) begin
						dir_q <= t1_q;
					end else begin
						b_q <= c_q;
						c_q <= b_q;
						dir_q <= dneg(t1_q);
					end
				end
				S_QD2: if (rsp.pos) begin
					b_q <= c_q;
					c_q <= d_q;
				end
				S_QD3: if (rsp.pos) begin
					b_q <= d_q;
					c_q <= b_q;
				end
				default: begin
				end
			endcase
		end
	end

	// output word straight from held registers, stable while stalled
	always_comb begin
		case (k_q)
			2'd0: vsel = a_q;
			2'd1: vsel = b_q;
			2'd2: vsel = c_q;
			default: vsel = d_q;
		endcase
		if (status_q == ST_CONT || status_q == ST_IGN) begin
			vsel = '0;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_EMIT);
	assign m_axis_tuser = status_q;
	assign m_axis_tlast = out_last;
	assign m_axis_tdata = {(OUT_W - OUT_FW)'(0), k_q, vsel,
		(status_q == ST_IGN) ? dvec_t'('0) : dir_q};

	// never both sides open at once
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output open together");

	// a running query always holds at least one vertex
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (count_q != 3'd0 && count_q <= 3'(NVTX)))
		else $error("active query with bad simplex count");

	// intersection always reports a full tetrahedron
	a_int_four: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_INT) |-> n_q == 3'(NVTX))
		else $error("intersection without four vertices");

	// a mac job is never issued twice in a row
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("mac job issued twice");

endmodule

// ----- rtl/gss_mac_unit.sv -----
// shared multiply-accumulate unit: cross product or dot-product sign, one product term at a time
module gss_mac_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  gss_pkg::mac_cmd_t cmd,
	input  gss_pkg::dvec_t   big_op,
	input  gss_pkg::svec_t   small_op,
	output gss_pkg::mac_rsp_t rsp,
	output gss_pkg::dvec_t   res
);
	import gss_pkg::*;

	logic busy_q, ph_q, dot_q, neg_q, done_q, pos_q;
	logic [2:0] cnt_q;
	logic signed [PRW-1:0] prod_q;
	logic signed [AW-1:0] acc_q, acc_nxt, pext;
	dvec_t res_q;
	logic [1:0] ui, vi;
	logic signed [DW-1:0] bsel;
	logic signed [SW-1:0] ssel;
	logic sub;

	// operand component selection per term
	always_comb begin
		ui = cnt_q[1:0];
		vi = cnt_q[1:0];
		if (!dot_q) begin
			case (cnt_q)
				3'd0: begin ui = 2'd1; vi = 2'd2; end
				3'd1: begin ui = 2'd2; vi = 2'd1; end
				3'd2: begin ui = 2'd2; vi = 2'd0; end
				3'd3: begin ui = 2'd0; vi = 2'd2; end
				3'd4: begin ui = 2'd0; vi = 2'd1; end
				default: begin ui = 2'd1; vi = 2'd0; end
			endcase
		end
		case (ui)
			2'd0: bsel = big_op.x;
			2'd1: bsel = big_op.y;
			default: bsel = big_op.z;
		endcase
		case (vi)
			2'd0: ssel = small_op.x;
			2'd1: ssel = small_op.y;
			default: ssel = small_op.z;
		endcase
	end

	assign sub = dot_q ? 1'b0 : (cnt_q[0] ^ neg_q);
	assign pext = AW'(prod_q);
	assign acc_nxt = sub ? (acc_q - pext) : (acc_q + pext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= 1'b0;
			cnt_q <= 3'd0;
			dot_q <= 1'b0;
			neg_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				ph_q <= 1'b0;
				cnt_q <= 3'd0;
				dot_q <= cmd.dot;
				neg_q <= cmd.neg;
			end else if (busy_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					if ((dot_q && cnt_q == 3'd2) || (!dot_q && cnt_q == 3'd5)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			if (!ph_q) begin
				prod_q <= bsel * ssel;
			end else if (dot_q) begin
				acc_q <= acc_nxt;
				pos_q <= !acc_nxt[AW-1] && (acc_nxt != '0);
			end else if (cnt_q[0]) begin
				acc_q <= '0;
				case (cnt_q[2:1])
					2'd0: res_q.x <= acc_nxt[DW-1:0];
					2'd1: res_q.y <= acc_nxt[DW-1:0];
					default: res_q.z <= acc_nxt[DW-1:0];
				endcase
			end else begin
				acc_q <= acc_nxt;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.pos = pos_q;
	assign res = res_q;

endmodule

// ----- tb/sv/gjk_simplex_step_unit_test.sv -----
// testbench of the gjk simplex step unit: directed table, box-shape queries, stream checks
module gjk_simplex_step_unit_test;
	import gss_pkg::*;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} vec3_t;

	// one output word as the monitor sees it
	typedef struct {
		logic [1:0]  status;
		vec3_t       dir;
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] vz;
		logic [1:0]  idx;
		logic        last;
	} word_t;

	// one directed row; typed rows carry their expected status and direction
	typedef struct {
		logic          op;
		shortint       x;
		shortint       y;
		shortint       z;
		bit            typed;
		logic [1:0]    st;
		longint        dx;
		longint        dy;
		longint        dz;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata = '0;   // point_x, point_y, point_z
	logic                s_axis_tuser = 1'b0; // opcode
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// dir_x, dir_y, dir_z, vertex_x, vertex_y, vertex_z, vertex_index, zero pad
	logic [OUT_W-1:0]    m_axis_tdata;
	logic [1:0]          m_axis_tuser;        // status
	logic                m_axis_tlast;

	gjk_simplex_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the simplex state
	vec3_t  simp [NVTX];
	int     simp_n;
	vec3_t  sdir;
	bit     q_active;

	word_t  pending_words[$];   // output words still owed by the block
	word_t  step_words[$];      // words caused by the item being predicted
	bit     failed = 1'b0;
	int     words_seen = 0;

	function automatic vec3_t vsub3(vec3_t a, vec3_t b);
		vec3_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic vec3_t vneg3(vec3_t a);
		vec3_t r;
		r.x = -a.x;
		r.y = -a.y;
		r.z = -a.z;
		return r;
	endfunction

	// wraps at 64 bits like the block
	function automatic vec3_t vcross3(vec3_t a, vec3_t b);
		vec3_t r;
		r.x = a.y * b.z - a.z * b.y;
		r.y = a.z * b.x - a.x * b.z;
		r.z = a.x * b.y - a.y * b.x;
		return r;
	endfunction

	// exact dot product at 128 bits, true when strictly positive
	function automatic bit dot_pos(vec3_t a, vec3_t b);
		logic signed [127:0] ax, ay, az, bx, by, bz, s;
		ax = a.x;
		ay = a.y;
		az = a.z;
		bx = b.x;
		by = b.y;
		bz = b.z;
		s = ax * bx + ay * by + az * bz;
		return !s[127] && s != 0;
	endfunction

	function automatic word_t mk_word(logic [1:0] st, vec3_t d, vec3_t v, int k, bit lst);
		word_t w;
		w.status = st;
		w.dir = d;
		w.vx = v.x[15:0];
		w.vy = v.y[15:0];
		w.vz = v.z[15:0];
		w.idx = k[1:0];
		w.last = lst;
		return w;
	endfunction

	task automatic line_red();
		vec3_t a, ab, ao;
		a = simp[0];
		ab = vsub3(simp[1], a);
		ao = vneg3(a);
		if (dot_pos(ab, ao)) begin
			sdir = vcross3(vcross3(ab, ao), ab);
		end else begin
			simp_n = 1;
			sdir = ao;
		end
	endtask

	task automatic tri_red();
		vec3_t a, b, c, ab, ac, ao, abc;
		a = simp[0];
		b = simp[1];
		c = simp[2];
		ab = vsub3(b, a);
		ac = vsub3(c, a);
		ao = vneg3(a);
		abc = vcross3(ab, ac);
		if (dot_pos(vcross3(abc, ac), ao)) begin
			if (dot_pos(ac, ao)) begin
				simp[1] = c;
				simp_n = 2;
				sdir = vcross3(vcross3(ac, ao), ac);
			end else begin
				simp_n = 2;
				line_red();
			end
		end else if (dot_pos(vcross3(ab, abc), ao)) begin
			simp_n = 2;
			line_red();
		end else if (dot_pos(abc, ao)) begin
			sdir = abc;
		end else begin
			// origin below the face: flip the winding
			simp[1] = c;
			simp[2] = b;
			sdir = vneg3(abc);
		end
	endtask

	// returns 1 when the tetrahedron holds the origin
	task automatic tetra_red(output bit hit);
		vec3_t a, b, c, d, ab, ac, ad, ao;
		a = simp[0];
		b = simp[1];
		c = simp[2];
		d = simp[3];
		ab = vsub3(b, a);
		ac = vsub3(c, a);
		ad = vsub3(d, a);
		ao = vneg3(a);
		hit = 1'b0;
		if (dot_pos(vcross3(ab, ac), ao)) begin
			simp_n = 3;
			tri_red();
		end else if (dot_pos(vcross3(ac, ad), ao)) begin
			simp[1] = c;
			simp[2] = d;
			simp_n = 3;
			tri_red();
		end else if (dot_pos(vcross3(ad, ab), ao)) begin
			simp[1] = d;
			simp[2] = b;
			simp_n = 3;
			tri_red();
		end else begin
			hit = 1'b1;
		end
	endtask

	task automatic end_query(logic [1:0] st);
		for (int k = 0; k < simp_n; k++)
			step_words.insert(step_words.size(),
				mk_word(st, sdir, simp[k], k, k + 1 == simp_n));
		q_active = 1'b0;
	endtask

	// works out the words that one accepted input word causes
	task automatic predict_step(logic op, shortint px, shortint py, shortint pz);
		vec3_t p, zv;
		bit hit;
		p.x = px;
		p.y = py;
		p.z = pz;
		zv = '{0, 0, 0};
		step_words.delete();
		if (op == OP_START) begin
			simp[0] = p;
			simp_n = 1;
			sdir = vneg3(p);
			q_active = 1'b1;
			step_words.insert(step_words.size(), mk_word(ST_CONT, sdir, zv, 0, 1'b1));
		end else if (!q_active) begin
			step_words.insert(step_words.size(), mk_word(ST_IGN, zv, zv, 0, 1'b1));
		end else if (!dot_pos(p, sdir)) begin
			end_query(ST_SEP);
		end else begin
			for (int k = NVTX - 1; k > 0; k--)
				simp[k] = simp[k-1];
			simp[0] = p;
			if (simp_n < NVTX)
				simp_n++;
			hit = 1'b0;
			if (simp_n == 2)
				line_red();
			else if (simp_n == 3)
				tri_red();
			else
				tetra_red(hit);
			if (hit)
				end_query(ST_INT);
			else
				step_words.insert(step_words.size(),
					mk_word(ST_CONT, sdir, zv, 0, 1'b1));
		end
	endtask

	// sender side: one word per call, gap drawn before it
	task automatic send_point(logic op, shortint px, shortint py, shortint pz, int gap);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {pz, py, px};
		do @(posedge clk); while (!s_axis_tready);
		predict_step(op, px, py, pz);
	endtask

	// box-shaped minkowski difference: support = center - half where dir is negative, else center + half
	function automatic shortint box_sup(int c, int h, longint d);
		return shortint'(d < 0 ? c - h : c + h);
	endfunction

	function automatic int rnd_sym(int m);
		return int'($urandom_range(2 * m)) - m;
	endfunction

	row_t rows[$];
	int   rx_hold_at;

	initial begin
		rows = '{
			// continue with no query running is ignored
			'{OP_CONT, 16'sd5, 16'sd5, 16'sd5, 1'b1, ST_IGN, 0, 0, 0},
			// seed at the origin gives a zero direction
			'{OP_START, 16'sd0, 16'sd0, 16'sd0, 1'b1, ST_CONT, 0, 0, 0},
			'{OP_CONT, 16'sd100, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0},
			'{OP_CONT, 16'sd1, 16'sd1, 16'sd1, 1'b1, ST_IGN, 0, 0, 0},
			// coordinate extremes
			'{OP_START, 16'sd32767, -16'sd32768, 16'sd1, 1'b1, ST_CONT,
				-32767, 32768, -1},
			'{OP_CONT, -16'sd32768, 16'sd32767, 16'sd0, 1'b0, 0, 0, 0, 0},
			'{OP_START, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, ST_CONT,
				32768, 32768, 32768},
			'{OP_CONT, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 0, 0, 0, 0},
			// origin on a line: zero direction, then separated
			'{OP_START, 16'sd10, 16'sd0, 16'sd0, 1'b1, ST_CONT, -10, 0, 0},
			'{OP_CONT, -16'sd10, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0},
			'{OP_CONT, 16'sd0, 16'sd5, 16'sd0, 1'b0, 0, 0, 0, 0},
			// tetrahedron around the origin
			'{OP_START, 16'sd10, 16'sd0, 16'sd0, 1'b1, ST_CONT, -10, 0, 0},
			'{OP_CONT, -16'sd10, 16'sd10, 16'sd1, 1'b0, 0, 0, 0, 0},
			'{OP_CONT, -16'sd10, -16'sd10, 16'sd10, 1'b0, 0, 0, 0, 0},
			'{OP_CONT, -16'sd10, -16'sd10, -16'sd10, 1'b0, 0, 0, 0, 0},
			'{OP_CONT, -16'sd10, 16'sd10, -16'sd10, 1'b0, 0, 0, 0, 0},
			// start abandons a running query
			'{OP_START, 16'sd300, -16'sd200, 16'sd50, 1'b1, ST_CONT, -300, 200, -50},
			'{OP_START, -16'sd7, 16'sd3, 16'sd9, 1'b1, ST_CONT, 7, -3, -9},
			'{OP_CONT, 16'sd0, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0}
		};
	end

	// stimulus
	initial begin
		int c[3];
		int h;
		int steps;
		int gap;
		bit burst;
		vec3_t zv;
		shortint px, py, pz;
		logic op;

		zv = '{0, 0, 0};
		simp = '{default: zv};
		simp_n = 0;
		sdir = zv;
		q_active = 1'b0;
		steps = 0;
		burst = 1'b0;
		h = 1;
		c = '{0, 0, 0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			send_point(rows[i].op, rows[i].x, rows[i].y, rows[i].z, $urandom_range(5));
			if (rows[i].typed) begin
				step_words.delete();
				step_words.insert(0, mk_word(rows[i].st,
					vec3_t'{rows[i].dx, rows[i].dy, rows[i].dz}, zv, 0, 1'b1));
			end
			foreach (step_words[k])
				pending_words.insert(pending_words.size(), step_words[k]);
		end

		for (int n = 0; n < 300; n++) begin
			// bursts of back-to-back words now and then
			if (n % 30 == 0)
				burst = ($urandom_range(2) == 0);
			gap = burst ? 0 : $urandom_range(5);
			if (n == 150) begin
				// drain the block before going on
				wait (pending_words.size() == 0);
				gap = 0;
			end
			if ($urandom_range(9) == 0) begin
				// noise: any opcode, any coordinate
				op = 1'($urandom_range(1));
				px = shortint'($urandom);
				py = shortint'($urandom);
				pz = shortint'($urandom);
			end else if (!q_active || steps >= 12) begin
				if ($urandom_range(4) == 0) begin
					foreach (c[k]) c[k] = rnd_sym(16000);
					h = $urandom_range(16000, 1);
				end else begin
					foreach (c[k]) c[k] = rnd_sym(2000);
					h = $urandom_range(2500, 1);
				end
				steps = 0;
				op = OP_START;
				px = box_sup(c[0], h, rnd_sym(1));
				py = box_sup(c[1], h, rnd_sym(1));
				pz = box_sup(c[2], h, rnd_sym(1));
			end else if ($urandom_range(19) == 0) begin
				// broken sequence: a point unrelated to the direction
				op = OP_CONT;
				px = shortint'(rnd_sym(3000));
				py = shortint'(rnd_sym(3000));
				pz = shortint'(rnd_sym(3000));
			end else begin
				op = OP_CONT;
				steps++;
				px = box_sup(c[0], h, sdir.x);
				py = box_sup(c[1], h, sdir.y);
				pz = box_sup(c[2], h, sdir.z);
			end
			send_point(op, px, py, pz, gap);
			foreach (step_words[k])
				pending_words.insert(pending_words.size(), step_words[k]);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		wait (pending_words.size() == 0);
		repeat (200) @(posedge clk);
		if (!failed) begin
			$display("gjk_simplex_step_unit_test OK");
		end else begin
			$display("gjk_simplex_step_unit_test NOT OK");
		end
		$finish;
	end

	// receiver: random stall per word, one long hold-off to back the block up
	initial begin
		int stall;
		int hold_cnt;
		bit burst;

		burst = 1'b0;
		rx_hold_at = 40;
		repeat (6) @(posedge clk);
		forever begin
			@(negedge clk);
			if (words_seen % 25 == 0)
				burst = ($urandom_range(2) == 0);
			stall = burst ? 0 : $urandom_range(5);
			if (words_seen == rx_hold_at) begin
				rx_hold_at = -1;
				stall = 400;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				hold_cnt = 0;
				while (hold_cnt < stall) begin
					@(negedge clk);
					hold_cnt++;
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// output checker
	always @(posedge clk) begin
		word_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_seen++;
			got.status = m_axis_tuser;
			got.dir.x = m_axis_tdata[63:0];
			got.dir.y = m_axis_tdata[127:64];
			got.dir.z = m_axis_tdata[191:128];
			got.vx = m_axis_tdata[207:192];
			got.vy = m_axis_tdata[223:208];
			got.vz = m_axis_tdata[239:224];
			got.idx = m_axis_tdata[241:240];
			got.last = m_axis_tlast;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word status %0d dir %0d %0d %0d", $realtime,
					got.status, got.dir.x, got.dir.y, got.dir.z);
				failed = 1'b1;
			end else begin
				want = pending_words.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime,
						want.status, got.status);
					failed = 1'b1;
				end
				if (got.dir.x != want.dir.x || got.dir.y != want.dir.y ||
					got.dir.z != want.dir.z) begin
					$display("%0t: dir expected %0d %0d %0d actual %0d %0d %0d", $realtime,
						want.dir.x, want.dir.y, want.dir.z, got.dir.x, got.dir.y, got.dir.z);
					failed = 1'b1;
				end
				if ({got.vx, got.vy, got.vz} !== {want.vx, want.vy, want.vz}) begin
					$display("%0t: vertex expected %h %h %h actual %h %h %h", $realtime,
						want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
					failed = 1'b1;
				end
				if (got.idx !== want.idx) begin
					$display("%0t: vertex_index expected %0d actual %0d", $realtime,
						want.idx, got.idx);
					failed = 1'b1;
				end
				if (got.last !== want.last) begin
					$display("%0t: tlast expected %0d actual %0d", $realtime,
						want.last, got.last);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog
	initial begin
		#2000000;
		$display("gjk_simplex_step_unit_test NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/gss_pkg.sv
rtl/gss_mac_unit.sv
rtl/gjk_simplex_step_unit.sv
tb/sv/gjk_simplex_step_unit_test.sv
